/* hdl/cdma_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cdma_pkg
// Shared types and constants of the cartridge DMA register block: request
// and response beat layouts, request and register codes, error codes, masks.
// ----------------------------------------------------------------------------
package cdma_pkg;

    // request types
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // register indexes
    localparam logic [3:0] REG_DRAM_ADDR    = 4'd0;
    localparam logic [3:0] REG_CART_ADDR    = 4'd1;
    localparam logic [3:0] REG_RD_LEN       = 4'd2;
    localparam logic [3:0] REG_WR_LEN       = 4'd3;
    localparam logic [3:0] REG_STATUS       = 4'd4;
    localparam logic [3:0] REG_TIMING_FIRST = 4'd5;
    localparam logic [3:0] REG_TIMING_LAST  = 4'd12;

    // error codes
    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_UNSUPPORTED = 2'd1;
    localparam logic [1:0] ERR_CART_FLOOR  = 2'd2;

    // dma directions
    localparam logic DIR_DRAM_TO_CART = 1'b0;
    localparam logic DIR_CART_TO_DRAM = 1'b1;

    // widths and masks
    localparam int DRAM_REG_W   = 24;
    localparam int DRAM_DMA_W   = 23;
    localparam int COUNT_W      = 25;
    localparam int COUNTDOWN_W  = 22;
    localparam int TIMING_COUNT = 8;

    localparam logic [DRAM_DMA_W-1:0]  DRAM_DMA_MASK = 23'h7FFFFE;
    localparam logic [31:0]            CART_DMA_MASK = 32'hFFFFFFFE;
    localparam logic [31:0]            LEN_MASK      = 32'h00FFFFFF;
    localparam logic [COUNTDOWN_W-1:0] COUNTDOWN_MAX = 22'h3FFFFF;
    localparam logic [31:0]            FLOOR_RESET   = 32'h06000000;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
        logic        mi_pi_pending;
    } req_t;

    typedef struct packed {
        logic [31:0]           read_data;
        logic                  dma_start;
        logic                  dma_direction;
        logic [DRAM_DMA_W-1:0] dma_dram_address;
        logic [31:0]           dma_cart_address;
        logic [COUNT_W-1:0]    dma_byte_count;
        logic                  irq_raise;
        logic                  irq_lower;
        logic [1:0]            error_code;
    } rsp_t;

    // dma command worked out from the address and length registers
    typedef struct packed {
        logic [DRAM_DMA_W-1:0]  dram_addr;
        logic [31:0]            cart_addr;
        logic [COUNT_W-1:0]     byte_count;
        logic [COUNTDOWN_W-1:0] countdown;
        logic                   below_floor;
    } dma_cmd_t;

endpackage
`default_nettype wire

/* hdl/cdma_cmd_calc.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cdma_cmd_calc
// Works out one dma command: aligned addresses, byte count with clamp on
// underflow, saturated busy countdown and the cartridge floor check.
// ----------------------------------------------------------------------------
module cdma_cmd_calc #(
    parameter int TICKS_PER_BYTE_SHIFT = 3
) (
    input  wire logic [cdma_pkg::DRAM_REG_W-1:0] dram_address,
    input  wire logic [31:0]                     cart_address,
    input  wire logic [31:0]                     length,
    input  wire logic [31:0]                     cart_floor,
    output cdma_pkg::dma_cmd_t                   cmd
);

    logic [cdma_pkg::DRAM_DMA_W-1:0] dram_al;
    logic [31:0]                     cart_al;
    logic [cdma_pkg::COUNT_W-1:0]    len_plus;
    logic [2:0]                      misalign;
    logic [cdma_pkg::COUNT_W-1:0]    count;
    logic [cdma_pkg::COUNT_W-1:0]    ticks;

    // aligned addresses
    assign dram_al  = dram_address[cdma_pkg::DRAM_DMA_W-1:0] & cdma_pkg::DRAM_DMA_MASK;
    assign cart_al  = cart_address & cdma_pkg::CART_DMA_MASK;
    assign misalign = dram_al[2:0];

    // byte count, clamped at zero
    assign len_plus = cdma_pkg::COUNT_W'(length & cdma_pkg::LEN_MASK) + cdma_pkg::COUNT_W'(1);
    assign count    = (cdma_pkg::COUNT_W'(misalign) > len_plus) ? '0
                    : len_plus - cdma_pkg::COUNT_W'(misalign);

    // busy countdown, saturated
    assign ticks = count >> TICKS_PER_BYTE_SHIFT;

    always_comb
    begin
        cmd.dram_addr   = dram_al;
        cmd.cart_addr   = cart_al;
        cmd.byte_count  = count;
        cmd.below_floor = cart_al < cart_floor;
        if (ticks > cdma_pkg::COUNT_W'(cdma_pkg::COUNTDOWN_MAX))
        begin
            cmd.countdown = cdma_pkg::COUNTDOWN_MAX;
        end
        else
        begin
            cmd.countdown = ticks[cdma_pkg::COUNTDOWN_W-1:0];
        end
    end

endmodule
`default_nettype wire

/* hdl/cartridge_dma_register_block.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cartridge_dma_register_block
// Register file of a cartridge dma interface: bus reads, writes and ticks.
// ----------------------------------------------------------------------------
// a request beat is held in the input register, then its response in the
// response register; state updates in the execute stage
// throughput: one request per cycle while rsp_stall is low
// reset: state registers, busy flags and countdown clear; floor is 0x06000000
// ----------------------------------------------------------------------------
module cartridge_dma_register_block #(
    parameter int TICKS_PER_BYTE_SHIFT = 3
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    // request channel
    input  wire logic           req_valid,
    output logic                req_stall,
    input  cdma_pkg::req_t      req,
    // response channel
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output cdma_pkg::rsp_t      rsp,
    // configuration write
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [31:0]    cfg_data
);

    localparam int TW = cdma_pkg::TIMING_COUNT;

    // pipeline control
    logic           ex_valid_reg;
    cdma_pkg::req_t ex_req_reg;
    logic           rsp_valid_reg;
    cdma_pkg::rsp_t rsp_reg;
    cdma_pkg::rsp_t rsp_next;
    logic           rsp_load;
    logic           ex_fire;
    logic           req_accept;

    // architectural state
    logic [31:0]                      floor_reg;
    logic [cdma_pkg::DRAM_REG_W-1:0]  dram_addr_reg,  dram_addr_next;
    logic [31:0]                      cart_addr_reg,  cart_addr_next;
    logic [31:0]                      rd_len_reg,     rd_len_next;
    logic [31:0]                      wr_len_reg,     wr_len_next;
    logic [7:0]                       timing_reg [TW];
    logic [7:0]                       timing_next [TW];
    logic                             dma_busy_reg,   dma_busy_next;
    logic                             io_busy_reg,    io_busy_next;
    logic [cdma_pkg::COUNTDOWN_W-1:0] countdown_reg,  countdown_next;

    logic [3:0]         timing_off;
    logic [2:0]         timing_idx;
    cdma_pkg::dma_cmd_t cmd;
    logic               dir;

    // handshakes
    assign rsp_load   = !rsp_valid_reg || !rsp_stall;
    assign ex_fire    = ex_valid_reg && rsp_load;
    assign req_stall  = ex_valid_reg && !rsp_load;
    assign req_accept = req_valid && !req_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;
    assign cfg_ready  = 1'b1;

    assign timing_off = ex_req_reg.reg_index - cdma_pkg::REG_TIMING_FIRST;
    assign timing_idx = timing_off[2:0];
    assign dir        = (ex_req_reg.reg_index == cdma_pkg::REG_WR_LEN)
                      ? cdma_pkg::DIR_CART_TO_DRAM : cdma_pkg::DIR_DRAM_TO_CART;

    // dma command from current addresses and the written length
    cdma_cmd_calc #(
        .TICKS_PER_BYTE_SHIFT(TICKS_PER_BYTE_SHIFT)
    ) u_cmd_calc (
        .dram_address(dram_addr_reg),
        .cart_address(cart_addr_reg),
        .length      (ex_req_reg.write_data),
        .cart_floor  (floor_reg),
        .cmd         (cmd)
    );

    // execute one request
    always_comb
    begin
        dram_addr_next = dram_addr_reg;
        cart_addr_next = cart_addr_reg;
        rd_len_next    = rd_len_reg;
        wr_len_next    = wr_len_reg;
        timing_next    = timing_reg;
        dma_busy_next  = dma_busy_reg;
        io_busy_next   = io_busy_reg;
        countdown_next = countdown_reg;
        rsp_next       = '0;

        unique case (ex_req_reg.req_type)
            cdma_pkg::REQ_READ:
            begin
                unique case (ex_req_reg.reg_index)
                    cdma_pkg::REG_DRAM_ADDR: rsp_next.read_data = 32'(dram_addr_reg);
                    cdma_pkg::REG_CART_ADDR: rsp_next.read_data = cart_addr_reg;
                    cdma_pkg::REG_RD_LEN:    rsp_next.read_data = rd_len_reg;
                    cdma_pkg::REG_WR_LEN:    rsp_next.read_data = wr_len_reg;
                    cdma_pkg::REG_STATUS:
                        rsp_next.read_data = {28'b0, ex_req_reg.mi_pi_pending, 1'b0,
                                              io_busy_reg, dma_busy_reg};
                    default:
                    begin
                        if (ex_req_reg.reg_index <= cdma_pkg::REG_TIMING_LAST)
                        begin
                            rsp_next.read_data = 32'(timing_reg[timing_idx]);
                        end
                        else
                        begin
                            rsp_next.error_code = cdma_pkg::ERR_UNSUPPORTED;
                        end
                    end
                endcase
            end
            cdma_pkg::REQ_WRITE:
            begin
                unique case (ex_req_reg.reg_index)
                    cdma_pkg::REG_DRAM_ADDR:
                        dram_addr_next = ex_req_reg.write_data[cdma_pkg::DRAM_REG_W-1:0];
                    cdma_pkg::REG_CART_ADDR:
                        cart_addr_next = ex_req_reg.write_data;
                    cdma_pkg::REG_RD_LEN, cdma_pkg::REG_WR_LEN:
                    begin
                        if (dir == cdma_pkg::DIR_CART_TO_DRAM)
                        begin
                            wr_len_next = ex_req_reg.write_data;
                        end
                        else
                        begin
                            rd_len_next = ex_req_reg.write_data;
                        end
                        if (cmd.below_floor)
                        begin
                            rsp_next.error_code = cdma_pkg::ERR_CART_FLOOR;
                        end
                        else
                        begin
                            rsp_next.dma_start        = 1'b1;
                            rsp_next.dma_direction    = dir;
                            rsp_next.dma_dram_address = cmd.dram_addr;
                            rsp_next.dma_cart_address = cmd.cart_addr;
                            rsp_next.dma_byte_count   = cmd.byte_count;
                            dma_busy_next             = 1'b1;
                            io_busy_next              = 1'b1;
                            countdown_next            = cmd.countdown;
                        end
                    end
                    cdma_pkg::REG_STATUS:
                        rsp_next.irq_lower = ex_req_reg.write_data[1];
                    default:
                    begin
                        if (ex_req_reg.reg_index <= cdma_pkg::REG_TIMING_LAST)
                        begin
                            timing_next[timing_idx] = ex_req_reg.write_data[7:0];
                        end
                        else
                        begin
                            rsp_next.error_code = cdma_pkg::ERR_UNSUPPORTED;
                        end
                    end
                endcase
            end
            cdma_pkg::REQ_TICK:
            begin
                // countdown runs only while busy
                if (dma_busy_reg || io_busy_reg)
                begin
                    if (countdown_reg <= cdma_pkg::COUNTDOWN_W'(1))
                    begin
                        countdown_next     = '0;
                        dma_busy_next      = 1'b0;
                        io_busy_next       = 1'b0;
                        rsp_next.irq_raise = 1'b1;
                    end
                    else
                    begin
                        countdown_next = countdown_reg - cdma_pkg::COUNTDOWN_W'(1);
                    end
                end
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            floor_reg     <= cdma_pkg::FLOOR_RESET;
            dram_addr_reg <= '0;
            cart_addr_reg <= '0;
            rd_len_reg    <= '0;
            wr_len_reg    <= '0;
            for (int i = 0; i < TW; i++)
            begin
                timing_reg[i] <= '0;
            end
            dma_busy_reg  <= 1'b0;
            io_busy_reg   <= 1'b0;
            countdown_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                floor_reg <= cfg_data;
            end
            if (!ex_valid_reg || rsp_load)
            begin
                ex_valid_reg <= req_accept;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= ex_valid_reg;
            end
            if (ex_fire)
            begin
                dram_addr_reg <= dram_addr_next;
                cart_addr_reg <= cart_addr_next;
                rd_len_reg    <= rd_len_next;
                wr_len_reg    <= wr_len_next;
                timing_reg    <= timing_next;
                dma_busy_reg  <= dma_busy_next;
                io_busy_reg   <= io_busy_next;
                countdown_reg <= countdown_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            ex_req_reg <= req;
        end
        if (ex_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule
`default_nettype wire

/* test/tb_cdma_scoreboard.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_cdma_scoreboard
// Predictor and scoreboard for the cartridge dma register block. Keeps its
// own copy of the registers, busy flags and countdown. Each accepted
// request beat yields one expected response, and responses are checked in
// order, field by field.
// ----------------------------------------------------------------------------
package tb_cdma_scoreboard_pkg;
    import cdma_pkg::*;

    localparam int BYTE_TICK_SHIFT = 3;

    class dma_reg_scoreboard;
        logic [31:0]            floor_q;
        logic [DRAM_REG_W-1:0]  dram_addr_q;
        logic [31:0]            cart_addr_q;
        logic [31:0]            rd_len_q;
        logic [31:0]            wr_len_q;
        logic [7:0]             timing_q [TIMING_COUNT];
        logic                   dma_busy_q;
        logic                   io_busy_q;
        logic [COUNTDOWN_W-1:0] countdown_q;
        rsp_t                   expected_rsp_q [$];
        int                     errors;

        function new();
            floor_q     = FLOOR_RESET;
            dram_addr_q = '0;
            cart_addr_q = '0;
            rd_len_q    = '0;
            wr_len_q    = '0;
            foreach (timing_q[i]) timing_q[i] = '0;
            dma_busy_q  = 1'b0;
            io_busy_q   = 1'b0;
            countdown_q = '0;
            errors      = 0;
        endfunction

        function void set_floor(logic [31:0] value);
            floor_q = value;
        endfunction

        function int pending_count();
            return expected_rsp_q.size();
        endfunction

        // work out the response of one accepted request and update state
        function void note_request(req_t beat);
            rsp_t                  want;
            logic [DRAM_DMA_W-1:0] dram;
            logic [31:0]           cart;
            logic [COUNT_W-1:0]    count;
            logic [COUNT_W-1:0]    ticks;
            logic [2:0]            misalign;
            logic [2:0]            tidx;
            want = '0;
            tidx = 3'(beat.reg_index - REG_TIMING_FIRST);
            case (beat.req_type)
                REQ_READ:
                begin
                    case (beat.reg_index)
                        REG_DRAM_ADDR: want.read_data = {8'd0, dram_addr_q};
                        REG_CART_ADDR: want.read_data = cart_addr_q;
                        REG_RD_LEN:    want.read_data = rd_len_q;
                        REG_WR_LEN:    want.read_data = wr_len_q;
                        REG_STATUS:
                            want.read_data = {28'd0, beat.mi_pi_pending, 1'b0,
                                              io_busy_q, dma_busy_q};
                        default:
                        begin
                            if (beat.reg_index <= REG_TIMING_LAST)
                                want.read_data = {24'd0, timing_q[tidx]};
                            else
                                want.error_code = ERR_UNSUPPORTED;
                        end
                    endcase
                end
                REQ_WRITE:
                begin
                    case (beat.reg_index)
                        REG_DRAM_ADDR: dram_addr_q = beat.write_data[DRAM_REG_W-1:0];
                        REG_CART_ADDR: cart_addr_q = beat.write_data;
                        REG_RD_LEN, REG_WR_LEN:
                        begin
                            // aligned addresses and byte count, clamped at zero
                            dram     = dram_addr_q[DRAM_DMA_W-1:0] & DRAM_DMA_MASK;
                            cart     = cart_addr_q & CART_DMA_MASK;
                            count    = {1'b0, beat.write_data[23:0]} + 25'd1;
                            misalign = dram[2:0];
                            count    = ({22'd0, misalign} > count) ? '0
                                     : count - {22'd0, misalign};
                            if (beat.reg_index == REG_RD_LEN)
                                rd_len_q = beat.write_data;
                            else
                                wr_len_q = beat.write_data;
                            if (cart < floor_q)
                                want.error_code = ERR_CART_FLOOR;
                            else
                            begin
                                want.dma_start        = 1'b1;
                                want.dma_direction    = (beat.reg_index == REG_WR_LEN) ?
                                                        DIR_CART_TO_DRAM : DIR_DRAM_TO_CART;
                                want.dma_dram_address = dram;
                                want.dma_cart_address = cart;
                                want.dma_byte_count   = count;
                                dma_busy_q            = 1'b1;
                                io_busy_q             = 1'b1;
                                ticks = count >> BYTE_TICK_SHIFT;
                                countdown_q = (ticks > {3'd0, COUNTDOWN_MAX}) ?
                                              COUNTDOWN_MAX : ticks[COUNTDOWN_W-1:0];
                            end
                        end
                        REG_STATUS: want.irq_lower = beat.write_data[1];
                        default:
                        begin
                            if (beat.reg_index <= REG_TIMING_LAST)
                                timing_q[tidx] = beat.write_data[7:0];
                            else
                                want.error_code = ERR_UNSUPPORTED;
                        end
                    endcase
                end
                REQ_TICK:
                begin
                    // countdown runs only while busy
                    if (dma_busy_q || io_busy_q)
                    begin
                        if (countdown_q <= COUNTDOWN_W'(1))
                        begin
                            countdown_q    = '0;
                            dma_busy_q     = 1'b0;
                            io_busy_q      = 1'b0;
                            want.irq_raise = 1'b1;
                        end
                        else
                            countdown_q = countdown_q - COUNTDOWN_W'(1);
                    end
                end
                default: ;
            endcase
            expected_rsp_q.push_back(want);
        endfunction

        function int field_diff(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
                return 1;
            end
            return 0;
        endfunction

        // compare one accepted response with the oldest expectation
        function void check_response(rsp_t got);
            rsp_t want;
            if (expected_rsp_q.size() == 0)
            begin
                $display("%0t: unexpected response: expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_rsp_q.pop_front();
            errors += field_diff("read_data", want.read_data, got.read_data);
            errors += field_diff("dma_start", want.dma_start, got.dma_start);
            errors += field_diff("dma_direction", want.dma_direction, got.dma_direction);
            errors += field_diff("dma_dram_address", want.dma_dram_address,
                                 got.dma_dram_address);
            errors += field_diff("dma_cart_address", want.dma_cart_address,
                                 got.dma_cart_address);
            errors += field_diff("dma_byte_count", want.dma_byte_count, got.dma_byte_count);
            errors += field_diff("irq_raise", want.irq_raise, got.irq_raise);
            errors += field_diff("irq_lower", want.irq_lower, got.irq_lower);
            errors += field_diff("error_code", want.error_code, got.error_code);
        endfunction
    endclass

endpackage
`default_nettype wire

/* test/tb_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the cartridge dma register block. A directed pass covers the
// register extremes, dma starts, the floor error, length underflow, status
// writes, ticks and unsupported requests. Random phases then run dma setup
// sequences with ticks, plus noise, under several floor settings, with
// bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;
    import cdma_pkg::*;
    import tb_cdma_scoreboard_pkg::*;

    localparam logic [1:0] REQ_RESERVED     = 2'd3;
    localparam logic [3:0] REG_UNSUPP_FIRST = 4'd13;
    localparam logic [3:0] REG_UNSUPP_LAST  = 4'd15;
    localparam int         PHASE_ITEMS      = 100;
    localparam int         PHASE_COUNT      = 5;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    req_t        req       = '0;
    logic        rsp_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [31:0] cfg_data  = '0;
    logic        req_stall;
    logic        rsp_valid;
    rsp_t        rsp;
    logic        cfg_ready;

    dma_reg_scoreboard sb;
    int          burst_left  = 0;
    int          items_sent  = 0;
    logic [31:0] cur_floor   = FLOOR_RESET;
    int          stall_cycle = 0;
    int          stall_mode  = 0;

    always #5 clk = ~clk;

    cartridge_dma_register_block #(
        .TICKS_PER_BYTE_SHIFT(BYTE_TICK_SHIFT)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // watch every accepted beat on all three channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_floor(cfg_data);
            if (req_valid && !req_stall)
                sb.note_request(req);
            if (rsp_valid && !rsp_stall)
                sb.check_response(rsp);
        end
    end

    // receiver stall pattern in one of four randomly chosen modes
    always @(posedge clk)
    begin
        stall_cycle <= stall_cycle + 1;
        if (stall_cycle % 48 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ((stall_cycle % 7) < 3);
        endcase
    end

    // send one request beat, with bursts and random gaps
    task automatic issue(input logic [1:0] kind, input logic [3:0] idx,
                         input logic [31:0] data);
        req_t beat;
        int   gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        beat.req_type      = kind;
        beat.reg_index     = idx;
        beat.write_data    = data;
        beat.mi_pi_pending = 1'($urandom_range(0, 1));
        req_valid <= 1'b1;
        req       <= beat;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        if (kind != REQ_RESERVED)
            items_sent++;
    endtask

    // stop sending and wait until every response is back
    task automatic drain();
        req_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending_count() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_floor(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cur_floor = value;
    endtask

    // cartridge address near the floor, on both sides of it
    function automatic logic [31:0] pick_cart(input logic [31:0] floor);
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return floor;
            2:       return floor - 32'd1;
            default: return (floor > 32'hFFFF_F000) ? 32'hFFFF_FFFF :
                            floor + $urandom_range(0, 4095);
        endcase
    endfunction

    // mostly short lengths so the countdown can expire
    function automatic logic [31:0] pick_len();
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        return ($urandom & 32'hFF00_0000) | $urandom_range(0, 96);
    endfunction

    // address setup, length write, then ticks with status polls
    task automatic dma_sequence();
        int n;
        if ($urandom_range(0, 4) != 0)
            issue(REQ_WRITE, REG_DRAM_ADDR, $urandom);
        if ($urandom_range(0, 4) != 0)
            issue(REQ_WRITE, REG_CART_ADDR, pick_cart(cur_floor));
        if ($urandom_range(0, 2) == 0)
            issue(REQ_READ, REG_STATUS, $urandom);
        issue(REQ_WRITE, ($urandom_range(0, 1) != 0) ? REG_WR_LEN : REG_RD_LEN, pick_len());
        n = $urandom_range(0, 14);
        repeat (n)
        begin
            if ($urandom_range(0, 3) == 0)
                issue(REQ_READ, REG_STATUS, $urandom);
            else
                issue(REQ_TICK, 4'($urandom_range(0, 15)), $urandom);
        end
    endtask

    task automatic random_phase(input int quota);
        int          first;
        int          sel;
        logic [3:0]  idx;
        first = items_sent;
        while (items_sent - first < quota)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 6)
                dma_sequence();
            else if (sel < 8)
                issue(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), $urandom);
            else if (sel == 8)
            begin
                // write then read back the same register
                idx = 4'($urandom_range(0, 15));
                issue(REQ_WRITE, idx, $urandom);
                issue(REQ_READ, idx, $urandom);
            end
            else
                repeat ($urandom_range(1, 20))
                    issue(REQ_TICK, 4'($urandom_range(0, 15)), $urandom);
            // let the pipeline run dry now and then
            if ($urandom_range(0, 39) == 0)
                drain();
        end
    endtask

    initial
    begin
        logic [31:0] next_floor;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register extremes and read back
        issue(REQ_READ, REG_STATUS, '0);
        issue(REQ_WRITE, REG_DRAM_ADDR, 32'hFFFF_FFFF);
        issue(REQ_READ, REG_DRAM_ADDR, '0);
        issue(REQ_WRITE, REG_CART_ADDR, 32'hFFFF_FFFF);
        issue(REQ_READ, REG_CART_ADDR, '0);
        // longest transfer from the top addresses
        issue(REQ_WRITE, REG_RD_LEN, 32'hFFFF_FFFF);
        issue(REQ_READ, REG_RD_LEN, '0);
        issue(REQ_READ, REG_STATUS, '0);
        issue(REQ_WRITE, REG_TIMING_FIRST, 32'hFFFF_FFFF);
        issue(REQ_WRITE, REG_TIMING_LAST, 32'h0000_0100);
        issue(REQ_READ, REG_TIMING_FIRST, '0);
        issue(REQ_READ, REG_TIMING_LAST, '0);
        // unsupported registers
        issue(REQ_WRITE, REG_UNSUPP_FIRST, 32'hFFFF_FFFF);
        issue(REQ_READ, REG_UNSUPP_LAST, '0);
        // status writes with and without the lower bit
        issue(REQ_WRITE, REG_STATUS, 32'h0000_0002);
        issue(REQ_WRITE, REG_STATUS, 32'hFFFF_FFFD);
        // cartridge address just below the floor
        issue(REQ_WRITE, REG_CART_ADDR, FLOOR_RESET - 32'd1);
        issue(REQ_WRITE, REG_WR_LEN, 32'h0000_0010);
        issue(REQ_READ, REG_WR_LEN, '0);
        // underflow with misaligned dram, restarting a busy countdown
        issue(REQ_WRITE, REG_DRAM_ADDR, 32'h0000_0006);
        issue(REQ_WRITE, REG_CART_ADDR, FLOOR_RESET);
        issue(REQ_WRITE, REG_WR_LEN, 32'h0000_0000);
        issue(REQ_TICK, '0, '0);
        issue(REQ_TICK, '0, '0);
        issue(REQ_RESERVED, REG_UNSUPP_LAST, 32'hFFFF_FFFF);
        // short transfer counted down by ticks
        issue(REQ_WRITE, REG_RD_LEN, 32'h0000_001F);
        repeat (4) issue(REQ_TICK, '0, '0);
        drain();

        // random phases under several floor settings
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p > 0)
            begin
                drain();
                case (p)
                    1:       next_floor = 32'h0000_0000;
                    2:       next_floor = 32'hFFFF_FFFF;
                    3:       next_floor = $urandom;
                    default: next_floor = FLOOR_RESET;
                endcase
                write_floor(next_floor);
            end
            random_phase(PHASE_ITEMS);
        end

        drain();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending_count() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #3000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire
